// File: hdl/rssc_pkg.sv
package rssc_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int MAG_W      = 27;
    localparam int GIDX_W     = 12;
    localparam int CNT_W      = 7;
    localparam int DROP_W     = 6;
    localparam int POS_W      = 6;
    localparam int NOISE_W    = 47;
    localparam int SPV_W      = 13;
    localparam int ACC_W      = 54;
    localparam int GSIZE_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_Z_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_DROP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_DROP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPV      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GPV      = 3'd6;

    localparam logic [CNT_W-1:0]   RST_Z_COUNT = CNT_W'(8);
    localparam logic [CNT_W-1:0]   RST_Y_COUNT = CNT_W'(1);
    localparam logic [SPV_W-1:0]   RST_SPV     = SPV_W'(8);
    localparam logic [SPV_W-1:0]   RST_GPV     = SPV_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_TERM,
        S_ACC,
        S_LOAD,
        S_ROOT
    } t_state;

    typedef struct packed {
        logic capture;
        logic mul;
        logic term;
        logic acc;
        logic root_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic group_end;
        logic root_busy;
        logic out_free;
    } t_status;

endpackage

// File: hdl/rssc_sqrt.sv
module rssc_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [2*rssc_pkg::MAG_W-1:0]    i_operand,
    output logic                            o_busy,
    output logic [rssc_pkg::MAG_W-1:0]      o_root
);
    import rssc_pkg::*;

    localparam int OP_W  = 2 * MAG_W;
    localparam int REM_W = MAG_W + 1;
    localparam int SH_W  = REM_W + 2;
    localparam int CTR_W = $clog2(MAG_W);

    logic [OP_W-1:0]  r_op;
    logic [REM_W-1:0] r_rem;
    logic [MAG_W-1:0] r_root;
    logic [CTR_W-1:0] r_cnt;
    logic             r_busy;

    logic [SH_W-1:0]  w_rem_sh;
    logic [SH_W-1:0]  w_trial;
    logic [SH_W-1:0]  w_diff;
    logic             w_fits;

    assign w_rem_sh = {r_rem, r_op[OP_W-1 -: 2]};
    assign w_trial  = SH_W'({r_root, 2'b01});
    assign w_fits   = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CTR_W'(MAG_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CTR_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_operand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_op <= {r_op[OP_W-3:0], 2'b00};
            if (w_fits) begin
                r_rem  <= w_diff[REM_W-1:0];
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[REM_W-1:0];
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// File: hdl/rssc_dp.sv
module rssc_dp #(
    parameter int MAX_VOXEL_SAMPLES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rssc_pkg::t_cmd                      i_cmd,
    output rssc_pkg::t_status                   o_status,
    input  logic signed [rssc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_cfg_we,
    input  logic [rssc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rssc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [rssc_pkg::MAG_W-1:0]          o_magnitude,
    output logic [rssc_pkg::GIDX_W-1:0]         o_group_index,
    output logic                                o_voxel_done
);
    import rssc_pkg::*;

    localparam int VCW    = (MAX_VOXEL_SAMPLES > 1) ? $clog2(MAX_VOXEL_SAMPLES) : 1;
    localparam int GCW    = $clog2(MAX_VOXEL_SAMPLES + 1);
    localparam int SPW    = ($clog2(MAX_VOXEL_SAMPLES + 1) > SPV_W) ?
                            $clog2(MAX_VOXEL_SAMPLES + 1) : SPV_W;
    localparam int NEED_W = GCW + 1 + GSIZE_W;
    localparam int CMP_W  = (GCW + 1 > SPV_W) ? GCW + 1 : SPV_W;
    localparam int SQ_W   = 2 * SAMPLE_W;
    localparam int TERM_W = SQ_W + 1;
    localparam int SUM_W  = ACC_W + 1;
    localparam int VC_CW  = SPW + 1;
    localparam logic [SPW-1:0]   SPV_HI  = SPW'(MAX_VOXEL_SAMPLES);
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // configuration
    logic [CNT_W-1:0]   r_z_count;
    logic [CNT_W-1:0]   r_y_count;
    logic [DROP_W-1:0]  r_z_drop;
    logic [DROP_W-1:0]  r_y_drop;
    logic [NOISE_W-1:0] r_noise;
    logic [SPV_W-1:0]   r_spv_cfg;
    logic [SPV_W-1:0]   r_gpv;

    // stream state
    logic [POS_W-1:0]   r_zpos;
    logic [POS_W-1:0]   r_ypos;
    logic [GCW-1:0]     r_gc;
    logic [VCW-1:0]     r_vc;
    logic [ACC_W-1:0]   r_acc;

    // item datapath
    logic [GSIZE_W-1:0] r_gsize;
    logic [SAMPLE_W-1:0] r_mag;
    logic [SQ_W-1:0]    r_sq;
    logic [NEED_W-1:0]  r_need;
    logic signed [TERM_W-1:0] r_term;
    logic [GCW-1:0]     r_gidx;
    logic               r_vdone;

    // output word
    logic               r_out_valid;
    logic [MAG_W-1:0]   r_magnitude;
    logic [GIDX_W-1:0]  r_group_index;
    logic               r_voxel_done;

    logic [CNT_W-1:0]   w_zc;
    logic [CNT_W-1:0]   w_yc;
    logic [2*CNT_W-1:0] w_gprod;
    logic [SPW-1:0]     w_spv_ext;
    logic [SPW-1:0]     w_spv;
    logic [SAMPLE_W-1:0] w_abs;
    logic [GCW:0]       w_gc_inc;
    logic [NEED_W-1:0]  w_need_prod;
    logic [SQ_W-1:0]    w_sq_prod;
    logic               w_active;
    logic               w_in_window;
    logic               w_z_last;
    logic               w_y_last;
    logic               w_group_end;
    logic               w_vox_end;
    logic               w_last_group;
    logic [VC_CW-1:0]   w_vc_inc;
    logic [SUM_W-1:0]   w_sum;
    logic [ACC_W-1:0]   w_sat;
    logic [2*MAG_W-1:0] w_root_op;
    logic               w_root_busy;
    logic [MAG_W-1:0]   w_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z_count <= RST_Z_COUNT;
            r_y_count <= RST_Y_COUNT;
            r_z_drop  <= '0;
            r_y_drop  <= '0;
            r_noise   <= '0;
            r_spv_cfg <= RST_SPV;
            r_gpv     <= RST_GPV;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_Z_COUNT: r_z_count <= i_cfg_data[CNT_W-1:0];
                CFG_Y_COUNT: r_y_count <= i_cfg_data[CNT_W-1:0];
                CFG_Z_DROP:  r_z_drop  <= i_cfg_data[DROP_W-1:0];
                CFG_Y_DROP:  r_y_drop  <= i_cfg_data[DROP_W-1:0];
                CFG_NOISE:   r_noise   <= i_cfg_data[NOISE_W-1:0];
                CFG_SPV:     r_spv_cfg <= i_cfg_data[SPV_W-1:0];
                CFG_GPV:     r_gpv     <= i_cfg_data[SPV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_z_count == '0) begin
            w_zc = CNT_W'(1);
        end else if (r_z_count > COUNT_MAX) begin
            w_zc = COUNT_MAX;
        end else begin
            w_zc = r_z_count;
        end
        if (r_y_count == '0) begin
            w_yc = CNT_W'(1);
        end else if (r_y_count > COUNT_MAX) begin
            w_yc = COUNT_MAX;
        end else begin
            w_yc = r_y_count;
        end
        w_spv_ext = SPW'(r_spv_cfg);
        if (w_spv_ext == '0) begin
            w_spv = SPW'(1);
        end else if (w_spv_ext > SPV_HI) begin
            w_spv = SPV_HI;
        end else begin
            w_spv = w_spv_ext;
        end
    end

    assign w_gprod     = (2*CNT_W)'(w_zc) * (2*CNT_W)'(w_yc);
    assign w_abs       = i_sample[SAMPLE_W-1] ? (~$unsigned(i_sample) + SAMPLE_W'(1))
                                              : $unsigned(i_sample);
    assign w_gc_inc    = (GCW+1)'(r_gc) + (GCW+1)'(1);
    assign w_need_prod = NEED_W'(w_gc_inc) * NEED_W'(r_gsize);
    assign w_sq_prod   = SQ_W'(r_mag) * SQ_W'(r_mag);

    // a group is live while fewer than min(groups_per_voxel, spv / gsize) are done
    assign w_active = (CMP_W'(r_gc) < CMP_W'(r_gpv)) && (r_need <= NEED_W'(w_spv));
    assign w_in_window = (r_zpos >= r_z_drop) &&
                         ((CNT_W'(r_zpos) + CNT_W'(r_z_drop)) < w_zc) &&
                         (r_ypos >= r_y_drop) &&
                         ((CNT_W'(r_ypos) + CNT_W'(r_y_drop)) < w_yc);
    assign w_z_last    = (CNT_W'(r_zpos) + CNT_W'(1)) >= w_zc;
    assign w_y_last    = (CNT_W'(r_ypos) + CNT_W'(1)) >= w_yc;
    assign w_group_end = w_active && w_z_last && w_y_last;
    assign w_last_group = (CMP_W'(w_gc_inc) >= CMP_W'(r_gpv)) ||
                          ((NEED_W+1)'(r_need) + (NEED_W+1)'(r_gsize) >
                           (NEED_W+1)'(w_spv));
    assign w_vc_inc    = VC_CW'(r_vc) + VC_CW'(1);
    assign w_vox_end   = w_vc_inc >= VC_CW'(w_spv);

    assign w_sum = {r_acc[ACC_W-1], r_acc} +
                   {{(SUM_W-TERM_W){r_term[TERM_W-1]}}, r_term};
    always_comb begin
        if (w_sum[SUM_W-1] != w_sum[SUM_W-2]) begin
            w_sat = w_sum[SUM_W-1] ? ACC_MIN : ACC_MAX;
        end else begin
            w_sat = w_sum[ACC_W-1:0];
        end
    end

    assign w_root_op = (!r_acc[ACC_W-1] && (r_acc != '0)) ? (2*MAG_W)'(r_acc) : '0;

    always_ff @(posedge i_clk) begin
        r_gsize <= w_gprod[GSIZE_W-1:0];
        if (i_cmd.capture) begin
            r_mag <= w_abs;
        end
        if (i_cmd.mul) begin
            r_sq   <= w_sq_prod;
            r_need <= w_need_prod;
        end
        if (i_cmd.term) begin
            r_term <= $signed({1'b0, r_sq}) -
                      $signed({{(TERM_W-NOISE_W){1'b0}}, r_noise});
        end
        if (i_cmd.acc && w_group_end) begin
            r_gidx  <= r_gc;
            r_vdone <= w_last_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zpos <= '0;
            r_ypos <= '0;
            r_gc   <= '0;
            r_vc   <= '0;
            r_acc  <= '0;
        end else if (i_cmd.root_load) begin
            r_acc <= '0;
        end else if (i_cmd.acc) begin
            if (w_active) begin
                if (w_in_window) begin
                    r_acc <= w_sat;
                end
                if (!w_z_last) begin
                    r_zpos <= r_zpos + POS_W'(1);
                end else begin
                    r_zpos <= '0;
                    if (!w_y_last) begin
                        r_ypos <= r_ypos + POS_W'(1);
                    end else begin
                        r_ypos <= '0;
                        r_gc   <= w_gc_inc[GCW-1:0];
                    end
                end
            end
            if (w_vox_end) begin
                r_zpos <= '0;
                r_ypos <= '0;
                r_gc   <= '0;
                r_vc   <= '0;
                if (!w_group_end) begin
                    r_acc <= '0;
                end
            end else begin
                r_vc <= r_vc + VCW'(1);
            end
        end
    end

    rssc_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.root_load),
        .i_operand (w_root_op),
        .o_busy    (w_root_busy),
        .o_root    (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_magnitude   <= w_root;
            r_group_index <= GIDX_W'(r_gidx);
            r_voxel_done  <= r_vdone;
        end
    end

    assign o_status.group_end = w_group_end;
    assign o_status.root_busy = w_root_busy;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_magnitude   = r_magnitude;
    assign o_group_index = r_group_index;
    assign o_voxel_done  = r_voxel_done;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output word overwritten while held");
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.root_load |=> (r_acc == '0))
        else $error("accumulator not cleared after group end");
    a_root_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.root_load |=> w_root_busy)
        else $error("square root did not start");
`endif

endmodule

// File: hdl/rssc_ctrl.sv
module rssc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rssc_pkg::t_status   i_status,
    output rssc_pkg::t_cmd      o_cmd
);
    import rssc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_TERM;
            S_TERM: n_state = S_ACC;
            S_ACC: begin
                n_state = i_status.group_end ? S_LOAD : S_IDLE;
            end
            S_LOAD: n_state = S_ROOT;
            S_ROOT: begin
                if (!i_status.root_busy && i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_MUL:  o_cmd.mul  = 1'b1;
            S_TERM: o_cmd.term = 1'b1;
            S_ACC:  o_cmd.acc  = 1'b1;
            S_LOAD: o_cmd.root_load = 1'b1;
            S_ROOT: o_cmd.out_load = !i_status.root_busy && i_status.out_free;
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_MUL && o_in_stall))
        else $error("accepted word did not enter the multiply step");
    a_no_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!i_status.root_busy && r_state == S_ROOT))
        else $error("result emitted before square root finished");
`endif

endmodule

// File: hdl/cropped_root_sum_of_squares_combiner.sv
// Cropped root-sum-of-squares combiner.
// Input channel: i_in_valid / o_in_stall carry one signed sample word per
// transfer. Samples of a voxel form groups of z_count * y_count words, z fastest;
// only the centered window is summed as sample^2 - noise_power, saturating.
// Output channel: o_out_valid / i_out_stall carry one word per completed group:
// floor square root of the clamped sum, group index and last-group flag.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_index
// (0 z_count, 1 y_count, 2 z_drop, 3 y_drop, 4 noise_power,
// 5 samples_per_voxel, 6 groups_per_voxel); write only while idle.
// Each sample word passes through the accept, square, noise subtract and
// accumulate steps; the next word is not taken until this word is through.
// A group-ending word then adds a load step and the one-bit-per-cycle square
// root unit, whose finished root is loaded once the output register is free.
// The output word sits in a register; while it is stalled the next group's
// samples keep flowing, and only a second group end waits for it to drain.
// Reset (synchronous, active low) loads the register defaults and clears the
// group and voxel position, the accumulator and the output valid.
module cropped_root_sum_of_squares_combiner #(
    parameter int MAX_VOXEL_SAMPLES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [rssc_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rssc_pkg::MAG_W-1:0]          o_magnitude,
    output logic [rssc_pkg::GIDX_W-1:0]         o_group_index,
    output logic                                o_voxel_done,
    input  logic                                i_cfg_we,
    input  logic [rssc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rssc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rssc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rssc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rssc_dp #(
        .MAX_VOXEL_SAMPLES (MAX_VOXEL_SAMPLES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_sample      (i_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_magnitude   (o_magnitude),
        .o_group_index (o_group_index),
        .o_voxel_done  (o_voxel_done)
    );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rssc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 50;
    localparam int REPORT_MAX   = 10;
    localparam int MAX_SAMPLES  = 4096;
    localparam int ITEMS_PER_SETTING = 100;

    typedef struct packed {
        logic [MAG_W-1:0]  magnitude;
        logic [GIDX_W-1:0] group_index;
        logic              voxel_done;
    } t_group_word;

    class rss_board;
        localparam longint SUM_MAX = (longint'(1) <<< 53) - 1;
        localparam longint SUM_MIN = -SUM_MAX - 1;

        logic [CNT_W-1:0]   z_count, y_count;
        logic [DROP_W-1:0]  z_drop, y_drop;
        logic [NOISE_W-1:0] noise_power;
        logic [SPV_W-1:0]   voxel_len, group_limit;
        int unsigned        z_pos, y_pos, group_cnt, voxel_pos;
        longint             power_sum;
        t_group_word        pending_words[$];
        int unsigned        mismatches;

        function new();
            z_count     = RST_Z_COUNT;
            y_count     = RST_Y_COUNT;
            z_drop      = '0;
            y_drop      = '0;
            noise_power = '0;
            voxel_len   = RST_SPV;
            group_limit = RST_GPV;
            mismatches  = 0;
            clear_position();
        endfunction

        function void clear_position();
            z_pos     = 0;
            y_pos     = 0;
            group_cnt = 0;
            voxel_pos = 0;
            power_sum = 0;
        endfunction

        function int unsigned clamp_count(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r, t;
            r = 0;
            for (int b = MAG_W - 1; b >= 0; b--) begin
                t = r | (longint'(1) << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_Z_COUNT: z_count     = data[CNT_W-1:0];
                CFG_Y_COUNT: y_count     = data[CNT_W-1:0];
                CFG_Z_DROP:  z_drop      = data[DROP_W-1:0];
                CFG_Y_DROP:  y_drop      = data[DROP_W-1:0];
                CFG_NOISE:   noise_power = data[NOISE_W-1:0];
                CFG_SPV:     voxel_len   = data[SPV_W-1:0];
                CFG_GPV:     group_limit = data[SPV_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] s);
            int unsigned zc, yc, vlen, groups;
            longint      amp, total;
            t_group_word w;
            zc     = clamp_count(z_count, 64);
            yc     = clamp_count(y_count, 64);
            vlen   = clamp_count(voxel_len, MAX_SAMPLES);
            groups = vlen / (zc * yc);
            if (groups > group_limit) groups = group_limit;
            if (group_cnt < groups) begin
                if (z_pos >= z_drop && z_pos + z_drop < zc &&
                    y_pos >= y_drop && y_pos + y_drop < yc) begin
                    amp = s;
                    if (amp < 0) amp = -amp;
                    total = power_sum + amp * amp - longint'(noise_power);
                    if (total > SUM_MAX) total = SUM_MAX;
                    if (total < SUM_MIN) total = SUM_MIN;
                    power_sum = total;
                end
                if (z_pos + 1 >= zc) begin
                    z_pos = 0;
                    if (y_pos + 1 >= yc) begin
                        y_pos = 0;
                        w.magnitude   = MAG_W'(floor_root(power_sum > 0 ? power_sum : 0));
                        w.group_index = GIDX_W'(group_cnt);
                        w.voxel_done  = (group_cnt + 1 >= groups);
                        pending_words.push_back(w);
                        group_cnt++;
                        power_sum = 0;
                    end else begin
                        y_pos++;
                    end
                end else begin
                    z_pos++;
                end
            end
            if (voxel_pos + 1 >= vlen) clear_position();
            else voxel_pos++;
        endfunction

        function void compare_word(logic [MAG_W-1:0] mag, logic [GIDX_W-1:0] gidx,
                                   logic done);
            t_group_word want;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: unexpected group word mag=%0d idx=%0d done=%0b",
                             mag, gidx, done);
                return;
            end
            want = pending_words.pop_front();
            if (mag !== want.magnitude || gidx !== want.group_index ||
                done !== want.voxel_done) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: mag/idx/done expected %0d/%0d/%0b, got %0d/%0d/%0b",
                             want.magnitude, want.group_index, want.voxel_done,
                             mag, gidx, done);
            end
        endfunction
    endclass

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [MAG_W-1:0]           magnitude;
    logic [GIDX_W-1:0]          group_index;
    logic                       voxel_done;
    logic                       cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycles         = 0;
    rss_board    board;

    cropped_root_sum_of_squares_combiner i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_sample      (sample),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_magnitude   (magnitude),
        .o_group_index (group_index),
        .o_voxel_done  (voxel_done),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            board.compare_word(magnitude, group_index, voxel_done);
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        board.take_sample(s);
    endtask

    // stop sending, let every pending word drain and the datapath go quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CNT_W-1:0] zc, input logic [CNT_W-1:0] yc,
                             input logic [DROP_W-1:0] zd, input logic [DROP_W-1:0] yd,
                             input logic [NOISE_W-1:0] noise,
                             input logic [SPV_W-1:0] vlen, input logic [SPV_W-1:0] glim);
        logic [CFG_IDX_W-1:0]  idx [7];
        logic [CFG_DATA_W-1:0] val [7];
        idx = '{CFG_Z_COUNT, CFG_Y_COUNT, CFG_Z_DROP, CFG_Y_DROP, CFG_NOISE, CFG_SPV, CFG_GPV};
        val = '{CFG_DATA_W'(zc), CFG_DATA_W'(yc), CFG_DATA_W'(zd), CFG_DATA_W'(yd),
                CFG_DATA_W'(noise), CFG_DATA_W'(vlen), CFG_DATA_W'(glim)};
        cfg_we <= 1'b1;
        foreach (idx[i]) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge i_clk);
            board.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
            1:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
            2:       return SAMPLE_W'(int'($urandom_range(4)) - 2);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [NOISE_W-1:0] random_noise();
        case ($urandom_range(9))
            0, 1, 2, 3: return '0;
            8:          return NOISE_W'({$urandom, $urandom});
            9:          return '1;
            default:    return NOISE_W'({$urandom, $urandom}) >> $urandom_range(40, 3);
        endcase
    endfunction

    task automatic random_setting(input int unsigned n);
        int unsigned zc, yc, groups, vlen, glim;
        case (n)
            1: configure(7'd64, 7'd1, 6'd31, 6'd0, random_noise(), 13'd130, 13'd3);
            4: configure(7'd1, 7'd64, 6'd0, 6'd63, random_noise(), 13'd200, 13'h1FFF);
            7: configure(7'd100, 7'd0, 6'd20, 6'd0, random_noise(), 13'h1FFF, 13'h1FFF);
            default: begin
                zc     = $urandom_range(8, 1);
                yc     = $urandom_range(4, 1);
                groups = $urandom_range(4, 1);
                vlen   = groups * zc * yc + $urandom_range(2);
                glim   = ($urandom_range(3) == 0) ? $urandom_range(5) : groups;
                configure(CNT_W'(zc), CNT_W'(yc), DROP_W'($urandom_range(zc / 2)),
                          DROP_W'($urandom_range(yc / 2)), random_noise(),
                          SPV_W'(vlen), SPV_W'(glim));
            end
        endcase
    endtask

    initial begin
        board = new();
        send_idle_pct  = 29;
        recv_stall_pct = 86;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one full-window group of eight
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        send_sample('0);
        send_sample('1);
        send_sample(SAMPLE_W'(1));
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        send_sample(SAMPLE_W'(12345));
        drain_results();

        // empty window, two groups, one trailing sample
        configure(7'd2, 7'd2, 6'd1, 6'd0, 47'd1000, 13'd9, 13'd5);
        repeat (9) send_sample(random_sample());
        drain_results();

        // zero counts act as one, zero groups per voxel: no words
        configure(7'd0, 7'd0, 6'd0, 6'd0, '1, 13'd0, 13'd0);
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
        drain_results();

        // oversized voxel length, noise larger than any square
        configure(7'd1, 7'd1, 6'd0, 6'd0, '1, 13'h1FFF, 13'd2);
        repeat (3) send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 29; recv_stall_pct = 86; end
                1: begin send_idle_pct = 86; recv_stall_pct = 29; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int j = 0; j < 3; j++) begin
                drain_results();
                random_setting(mode * 3 + j);
                for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
                    if ($urandom_range(149) == 0) drain_results();
                    send_sample(random_sample());
                end
            end
        end

        drain_results();
        if (board.mismatches == 0 && board.pending_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
